// ----- src/pu_pkg.sv -----
// ----------------------------------------------------------------------------
// pu_pkg: shared types and constants for the picture-unit register port
// Holds the opcodes, register numbers and the queue word passed from the
// front end to the back end.
// ----------------------------------------------------------------------------
package pu_pkg;

   typedef enum logic [1:0] {
      OP_WRITE = 2'd0,
      OP_READ  = 2'd1,
      OP_TICK  = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   localparam logic [2:0] REG_CTRL1  = 3'd0;
   localparam logic [2:0] REG_CTRL2  = 3'd1;
   localparam logic [2:0] REG_STATUS = 3'd2;
   localparam logic [2:0] REG_OAMADR = 3'd3;
   localparam logic [2:0] REG_OAMDAT = 3'd4;
   localparam logic [2:0] REG_SCROLL = 3'd5;
   localparam logic [2:0] REG_ADDR   = 3'd6;
   localparam logic [2:0] REG_DATA   = 3'd7;

   localparam logic CFG_MIRROR  = 1'b0;
   localparam logic CFG_PROTECT = 1'b1;

   // classified word from front end to back end
   typedef struct packed {
      op_type      op;
      logic [2:0]  reg_index;
      logic [7:0]  write_data;
   } item_type;

endpackage

// ----- src/pu_front.sv -----
// ----------------------------------------------------------------------------
// pu_front: input stage and two-entry queue
// Accepts request words and buffers them for the back end.
// ----------------------------------------------------------------------------
module pu_front
   import pu_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_opcode,
   input  logic [2:0]  req_reg_index,
   input  logic [7:0]  req_write_data,
   output logic        q_valid,
   input  logic        q_ready,
   output item_type    q_item
);

   item_type   mem_ff [2];
   logic       wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push, pop;

   assign req_ready = (cnt_ff != 2'd2);
   assign push      = req_valid && req_ready;
   assign q_valid   = (cnt_ff != 2'd0);
   assign pop       = q_valid && q_ready;
   assign q_item    = mem_ff[rp_ff];

   // advance pointers and count
   always_comb begin
      wp_in  = push ? ~wp_ff : wp_ff;
      rp_in  = pop ? ~rp_ff : rp_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   // store classified word
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wp_ff] <= '{op: op_type'(req_opcode), reg_index: req_reg_index,
                            write_data: req_write_data};
      end
   end

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff != 2'd3) else $error("queue count overflow");
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd2) |-> !push) else $error("push into full queue");
   a_pop_count: assert property (@(posedge clock) disable iff (reset)
      (pop && !push) |=> (cnt_ff == $past(cnt_ff) - 2'd1)) else $error("pop count");

endmodule

// ----- src/pu_back.sv -----
// ----------------------------------------------------------------------------
// pu_back: register file, memories and result register
// Executes each word as an issue state (memory read launched), then a
// complete state (state update, memory write, result loaded).
// ----------------------------------------------------------------------------
module pu_back
   import pu_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic        csr_index,
   input  logic [1:0]  csr_write_data,
   input  logic        q_valid,
   output logic        q_ready,
   input  item_type    q_item,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_read_data,
   output logic        rsp_nmi_request
);

   typedef enum logic {ST_ISSUE, ST_DONE} state_type;

   state_type   state_ff;
   item_type    cur_ff;
   logic [1:0]  mirror_ff;
   logic        protect_ff;
   logic [7:0]  ctrl1_ff, ctrl2_ff, status_ff, oam_adr_ff, hi_latch_ff, rbuf_ff;
   logic        toggle_ff;
   logic [14:0] temp_ff;
   logic [15:0] live_ff, vaddr_ff;
   logic [2:0]  fine_x_ff;
   logic [8:0]  line_ff;
   logic        out_valid_ff;
   logic [7:0]  out_data_ff;
   logic        out_nmi_ff;

   logic [7:0]  sprite_mem [256];
   logic [7:0]  pal_mem    [32];
   logic [7:0]  nt_mem     [2048];
   logic [7:0]  pat_mem    [8192];
   logic [7:0]  pal_rd_ff, nt_rd_ff, pat_rd_ff;

   // address decode of the video address
   logic [13:0] va;
   logic [1:0]  sel;
   logic        page;
   logic [10:0] nt_idx;
   logic        is_pal, is_nt;
   assign va     = vaddr_ff[13:0];
   assign sel    = va[11:10];
   assign is_pal = (va[13:8] == 6'h3f);
   assign is_nt  = va[13] && !is_pal;
   always_comb begin
      case (mirror_ff)
         2'd0:    page = sel[1];
         2'd1:    page = sel[0];
         2'd2:    page = 1'b0;
         default: page = 1'b1;
      endcase
   end
   assign nt_idx = {page, va[9:0]};

   // launch reads at issue time
   always_ff @(posedge clock) begin
      pal_rd_ff <= pal_mem[va[4:0]];
      nt_rd_ff  <= nt_mem[nt_idx];
      pat_rd_ff <= pat_mem[va[12:0]];
   end

   logic [7:0] mem_rd;
   assign mem_rd = is_pal ? pal_rd_ff : (is_nt ? nt_rd_ff : pat_rd_ff);

   logic is_wr, is_rd, is_tick, out_free, fire;
   assign is_wr    = (cur_ff.op == OP_WRITE);
   assign is_rd    = (cur_ff.op == OP_READ);
   assign is_tick  = (cur_ff.op == OP_TICK);
   assign out_free = !out_valid_ff || rsp_ready;
   assign fire     = (state_ff == ST_DONE) && out_free;
   assign q_ready  = (state_ff == ST_ISSUE);

   logic [15:0] vaddr_step;
   assign vaddr_step = vaddr_ff + (ctrl1_ff[2] ? 16'h0020 : 16'h0001);

   // tick scroll update
   logic [15:0] d0, d1, d2;
   logic [4:0]  ty;
   logic [8:0]  line_inc;
   always_comb begin
      d0 = (live_ff & 16'h7be0) | ({1'b0, temp_ff} & 16'h041f);
      d1 = d0 + 16'h1000;
      ty = d1[9:5] + 5'd1;
      d2 = d1;
      if (d1[15]) begin
         d2 = d1 & 16'h7c1f;
         if (d1[9:5] == 5'd29) d2 = d2 ^ 16'h0800;
         else d2 = d2 | {6'd0, ty, 5'd0};
      end
      line_inc = line_ff + 9'd1;
   end

   logic [7:0]  wd;
   logic [14:0] temp_wr;
   assign wd      = cur_ff.write_data;
   assign temp_wr = {temp_ff[14:8], wd};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_ISSUE;
         mirror_ff    <= 2'd0;
         protect_ff   <= 1'b0;
         ctrl1_ff     <= '0;
         ctrl2_ff     <= '0;
         status_ff    <= '0;
         oam_adr_ff   <= '0;
         hi_latch_ff  <= '0;
         rbuf_ff      <= '0;
         toggle_ff    <= 1'b0;
         temp_ff      <= '0;
         live_ff      <= '0;
         vaddr_ff     <= '0;
         fine_x_ff    <= '0;
         line_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            if (csr_index == CFG_MIRROR) mirror_ff <= csr_write_data;
            else protect_ff <= csr_write_data[0];
         end
         if (out_valid_ff && rsp_ready) out_valid_ff <= 1'b0;
         case (state_ff)
            ST_ISSUE: begin
               if (q_valid) begin
                  cur_ff   <= q_item;
                  state_ff <= ST_DONE;
               end
            end
            ST_DONE: begin
               if (fire) begin
                  state_ff     <= ST_ISSUE;
                  out_valid_ff <= 1'b1;
                  out_data_ff  <= 8'd0;
                  out_nmi_ff   <= 1'b0;
                  if (is_wr) begin
                     case (cur_ff.reg_index)
                        REG_CTRL1: begin
                           ctrl1_ff <= wd;
                           temp_ff  <= {temp_ff[14:12], wd[1:0], temp_ff[9:0]};
                        end
                        REG_CTRL2:  ctrl2_ff <= wd;
                        REG_OAMADR: oam_adr_ff <= wd;
                        REG_OAMDAT: oam_adr_ff <= oam_adr_ff + 8'd1;
                        REG_SCROLL: begin
                           toggle_ff <= ~toggle_ff;
                           if (toggle_ff)
                              temp_ff <= {wd[2:0], temp_ff[11:10], wd[7:3], temp_ff[4:0]};
                           else begin
                              temp_ff   <= {temp_ff[14:5], wd[7:3]};
                              fine_x_ff <= wd[2:0];
                           end
                        end
                        REG_ADDR: begin
                           toggle_ff <= ~toggle_ff;
                           if (toggle_ff) begin
                              vaddr_ff <= {hi_latch_ff, wd};
                              temp_ff  <= temp_wr;
                              live_ff  <= {1'b0, temp_wr};
                           end else begin
                              hi_latch_ff <= wd;
                              temp_ff     <= {1'b0, wd[5:0], temp_ff[7:0]};
                           end
                        end
                        REG_DATA: vaddr_ff <= vaddr_step;
                        default: ;
                     endcase
                  end else if (is_rd) begin
                     if (cur_ff.reg_index != REG_DATA) begin
                        out_data_ff <= status_ff;
                        status_ff   <= {1'b0, status_ff[6:0]};
                        toggle_ff   <= 1'b0;
                     end else begin
                        out_data_ff <= rbuf_ff;
                        rbuf_ff     <= mem_rd;
                        vaddr_ff    <= vaddr_step;
                     end
                  end else if (is_tick) begin
                     if (line_ff < 9'd240) live_ff <= d2;
                     else if (line_ff == 9'd240) status_ff <= 8'h80;
                     if (line_inc == 9'd262) begin
                        status_ff <= 8'h00;
                        line_ff   <= 9'd0;
                        live_ff   <= {1'b0, temp_ff};
                     end else begin
                        line_ff <= line_inc;
                     end
                     out_nmi_ff <= ctrl1_ff[7] && (line_inc == 9'd243);
                  end
               end
            end
            default: state_ff <= ST_ISSUE;
         endcase
      end
   end

   // memory writes at completion
   always_ff @(posedge clock) begin
      if (fire && is_wr && cur_ff.reg_index == REG_OAMDAT)
         sprite_mem[oam_adr_ff] <= wd;
      if (fire && is_wr && cur_ff.reg_index == REG_DATA) begin
         if (is_pal) begin
            if (va[1:0] == 2'b00) begin
               pal_mem[{1'b0, va[3:0]}] <= wd;
               pal_mem[{1'b1, va[3:0]}] <= wd;
            end else begin
               pal_mem[va[4:0]] <= wd;
            end
         end else if (is_nt) begin
            nt_mem[nt_idx] <= wd;
         end else if (!protect_ff) begin
            pat_mem[va[12:0]] <= wd;
         end
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_read_data   = out_data_ff;
   assign rsp_nmi_request = out_nmi_ff;

   a_line_range: assert property (@(posedge clock) disable iff (reset)
      line_ff < 9'd262) else $error("line counter out of range");
   a_hold_out: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_read_data)))
      else $error("result lost");
   a_nmi_tick: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_nmi_request) |-> (line_ff == 9'd243)) else $error("stray nmi");

endmodule

// ----- src/picture_unit_register_port.sv -----
// ----------------------------------------------------------------------------
// picture_unit_register_port: CPU register interface of a picture unit
// Each request word is a register write, read or scanline tick and yields one
// response word. The back end runs each word through an issue state (memory
// read launched) and a complete state (state update and write), and takes no
// new word until the last one completes; a two-entry queue decouples request
// intake from the back end, and a response register lets the next word start
// while a result waits. Stores come up undefined and need no clearing pass.
// ----------------------------------------------------------------------------
module picture_unit_register_port
   import pu_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_opcode,
   input  logic [2:0]  req_reg_index,
   input  logic [7:0]  req_write_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_read_data,
   output logic        rsp_nmi_request,
   input  logic        csr_write_enable,
   input  logic        csr_index,
   input  logic [1:0]  csr_write_data
);

   logic     q_valid, q_ready;
   item_type q_item;

   pu_front u_front (
      .clock, .reset, .req_valid, .req_ready, .req_opcode, .req_reg_index,
      .req_write_data, .q_valid, .q_ready, .q_item
   );

   pu_back u_back (
      .clock, .reset, .csr_write_enable, .csr_index, .csr_write_data,
      .q_valid, .q_ready, .q_item, .rsp_valid, .rsp_ready, .rsp_read_data,
      .rsp_nmi_request
   );

endmodule

// ----- verif/picture_unit_register_port_test.sv -----
// ----------------------------------------------------------------------------
// picture_unit_register_port_test: self-checking bench for the register port
// Drives CPU register writes, reads and scanline ticks into the block,
// predicts every response word from a behavioral copy of the register file
// and video memory, and compares each word field by field. Runs four
// mirroring and write-protect settings with random idling on both sides.
// ----------------------------------------------------------------------------
module picture_unit_register_port_test;
   import pu_pkg::*;

   localparam int WATCHDOG_LIMIT = 3000;
   localparam int PAL_BASE = 0;
   localparam int NT_BASE  = 32;
   localparam int PAT_BASE = 32 + 2048;
   localparam int MEM_SLOTS = 32 + 2048 + 8192;

   typedef struct {
      logic [7:0] read_data;
      logic       nmi_request;
   } response_word;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [1:0] req_opcode = 2'd0;
   logic [2:0] req_reg_index = 3'd0;
   logic [7:0] req_write_data = 8'd0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [7:0] rsp_read_data;
   logic       rsp_nmi_request;
   logic       csr_write_enable = 1'b0;
   logic       csr_index = 1'b0;
   logic [1:0] csr_write_data = 2'd0;

   picture_unit_register_port dut (.*);

   // clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // ---- predicted block state ----
   logic [1:0]  mirror_sel;
   logic        pattern_locked;
   logic [7:0]  ctrl_one, ctrl_two, status_now, oam_addr;
   logic [7:0]  oam_mem [256];
   logic        toggle;
   logic [14:0] t_addr;
   logic [15:0] v_scroll;
   logic [2:0]  fine_scroll;
   logic [15:0] v_addr;
   logic [7:0]  addr_hi;
   logic [7:0]  data_buffer;
   logic [8:0]  scanline;
   logic [7:0]  vram [MEM_SLOTS];
   bit          vram_written [MEM_SLOTS];

   item_type     pending_words [$];
   response_word expected_words [$];

   int errors = 0;
   int words_sent = 0;
   int reads_seen = 0, ticks_seen = 0, nmis_seen = 0;
   bit quiet = 1'b0;

   // locate the store entry behind a video address
   function automatic int vram_slot(input logic [15:0] a);
      logic [13:0] m;
      logic        page;
      m = a[13:0];
      if (m >= 14'h3f00) return PAL_BASE + m[4:0];
      if (m >= 14'h2000) begin
         case (mirror_sel)
            2'd0: page = m[11];
            2'd1: page = m[10];
            2'd2: page = 1'b0;
            default: page = 1'b1;
         endcase
         return NT_BASE + {page, m[9:0]};
      end
      return PAT_BASE + m[12:0];
   endfunction

   function automatic void store_vram(input logic [15:0] a, input logic [7:0] v);
      int s;
      s = vram_slot(a);
      if (s < NT_BASE) begin
         if ((a & 16'h3f03) == 16'h3f00) begin
            vram[a[3:0]] = v;
            vram[16 + a[3:0]] = v;
            vram_written[a[3:0]] = 1'b1;
            vram_written[16 + a[3:0]] = 1'b1;
         end else begin
            vram[s] = v;
            vram_written[s] = 1'b1;
         end
      end else if (s < PAT_BASE || !pattern_locked) begin
         vram[s] = v;
         vram_written[s] = 1'b1;
      end
   endfunction

   function automatic void step_address();
      v_addr = v_addr + (ctrl_one[2] ? 16'h0020 : 16'h0001);
   endfunction

   // advance one scanline, return the interrupt request
   function automatic logic advance_scanline();
      logic [15:0] d, t;
      if (scanline < 9'd240) begin
         d = (v_scroll & 16'h7be0) | ({1'b0, t_addr} & 16'h041f);
         d = d + 16'h1000;
         if (d[15]) begin
            t = (d & 16'h03e0) + 16'h0020;
            d = d & 16'h7c1f;
            if (t == 16'h03c0) d = d ^ 16'h0800;
            else d = d | (t & 16'h03e0);
         end
         v_scroll = d;
      end else if (scanline == 9'd240) begin
         status_now = 8'h80;
      end
      scanline = scanline + 9'd1;
      if (scanline == 9'd262) begin
         status_now = 8'h00;
         scanline = 9'd0;
         v_scroll = {1'b0, t_addr};
      end
      return ctrl_one[7] && scanline == 9'd243;
   endfunction

   function automatic void apply_register_write(input logic [2:0] r, input logic [7:0] v);
      case (r)
         REG_CTRL1: begin
            ctrl_one = v;
            t_addr = (t_addr & 15'h73ff) | {3'b0, v[1:0], 10'b0};
         end
         REG_CTRL2: ctrl_two = v;
         REG_OAMADR: oam_addr = v;
         REG_OAMDAT: begin
            oam_mem[oam_addr] = v;
            oam_addr = oam_addr + 8'd1;
         end
         REG_SCROLL: begin
            if (toggle) begin
               toggle = 1'b0;
               t_addr = (t_addr & 15'h0c1f) | {v[2:0], 12'b0}
                        | ({5'b0, v, 2'b0} & 15'h03e0);
            end else begin
               toggle = 1'b1;
               t_addr = (t_addr & 15'h7fe0) | {10'b0, v[7:3]};
               fine_scroll = v[2:0];
            end
         end
         REG_ADDR: begin
            if (toggle) begin
               toggle = 1'b0;
               v_addr = {addr_hi, v};
               t_addr = (t_addr & 15'h7f00) | {7'b0, v};
               v_scroll = {1'b0, t_addr};
            end else begin
               toggle = 1'b1;
               addr_hi = v;
               t_addr = (t_addr & 15'h00ff) | {1'b0, v[5:0], 8'b0};
            end
         end
         REG_DATA: begin
            store_vram(v_addr, v);
            step_address();
         end
         default: ;
      endcase
   endfunction

   function automatic logic [7:0] apply_register_read(input logic [2:0] r);
      logic [7:0] ret;
      if (r != REG_DATA) begin
         ret = status_now;
         status_now[7] = 1'b0;
         toggle = 1'b0;
      end else begin
         ret = data_buffer;
         data_buffer = vram[vram_slot(v_addr)];
         step_address();
      end
      return ret;
   endfunction

   // queue one word and its predicted response; never read an unwritten entry
   task automatic send_word(input op_type op, input logic [2:0] r, input logic [7:0] v);
      item_type     w;
      response_word e;
      if (op == OP_READ && r == REG_DATA && !vram_written[vram_slot(v_addr)]) r = REG_STATUS;
      w.op = op;
      w.reg_index = r;
      w.write_data = v;
      e.read_data = 8'd0;
      e.nmi_request = 1'b0;
      case (op)
         OP_WRITE: apply_register_write(r, v);
         OP_READ:  e.read_data = apply_register_read(r);
         OP_TICK:  e.nmi_request = advance_scanline();
         default: ;
      endcase
      pending_words.push_back(w);
      expected_words.push_back(e);
      words_sent++;
   endtask

   task automatic set_vram_address(input logic [15:0] a);
      send_word(OP_READ, REG_STATUS, 8'd0);
      send_word(OP_WRITE, REG_ADDR, a[15:8]);
      send_word(OP_WRITE, REG_ADDR, a[7:0]);
   endtask

   // hold until the block has nothing outstanding
   task automatic wait_idle();
      while (pending_words.size() != 0 || req_valid || expected_words.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_settings(input logic [1:0] m, input logic p);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= CFG_MIRROR;
      csr_write_data <= m;
      @(posedge clock);
      csr_index <= CFG_PROTECT;
      csr_write_data <= {1'b0, p};
      @(posedge clock);
      csr_write_enable <= 1'b0;
      mirror_sel = m;
      pattern_locked = p;
   endtask

   function automatic logic [15:0] pick_base();
      logic [15:0] a;
      case ($urandom_range(0, 3))
         0: a = 16'($urandom_range(0, 16'h1fff));
         1: a = 16'($urandom_range(16'h2000, 16'h3eff));
         2: a = 16'($urandom_range(16'h3f00, 16'h3fff));
         default: a = 16'($urandom_range(16'h2000, 16'h23ff));
      endcase
      if ($urandom_range(0, 5) == 0) a[15:14] = 2'($urandom);
      return a;
   endfunction

   // drive request words, with idle bursts
   int send_gap = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!(req_valid && !req_ready)) begin
         if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (pending_words.size() != 0) begin
            item_type w;
            w = pending_words.pop_front();
            req_valid <= 1'b1;
            req_opcode <= w.op;
            req_reg_index <= w.reg_index;
            req_write_data <= w.write_data;
            if (!quiet && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 11);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // stall the response side in bursts
   int recv_stall = 0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (recv_stall > 0) begin
         recv_stall--;
         rsp_ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
         recv_stall = $urandom_range(0, 10);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   task automatic report(input string what, input int got, input int want);
      $display("mismatch on %s: got %0h, expected %0h", what, got, want);
      errors++;
   endtask

   // compare each response word with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         response_word e;
         if (expected_words.size() == 0) begin
            report("unexpected word", int'(rsp_read_data), 0);
         end else begin
            e = expected_words.pop_front();
            if (rsp_read_data !== e.read_data)
               report("read_data", int'(rsp_read_data), int'(e.read_data));
            if (rsp_nmi_request !== e.nmi_request)
               report("nmi_request", int'(rsp_nmi_request), int'(e.nmi_request));
            if (e.nmi_request) nmis_seen++;
         end
      end
   end

   // end the run when nothing moves for too long
   int idle_cycles = 0;
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_write_enable)
         idle_cycles = 0;
      else if (++idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog expired with %0d words outstanding", expected_words.size());
         $display("picture_unit_register_port_test: errors");
         $finish;
      end
   end

   initial begin
      logic [15:0] base;
      int n, phase, kind;
      logic [1:0] mirror_plan [4];
      logic       lock_plan [4];
      mirror_plan = '{2'd0, 2'd3, 2'd1, 2'd2};
      lock_plan = '{1'b0, 1'b1, 1'b0, 1'b1};
      base = 16'h0000;
      mirror_sel = 2'd0; pattern_locked = 1'b0;
      ctrl_one = 0; ctrl_two = 0; status_now = 0; oam_addr = 0; toggle = 0;
      t_addr = 0; v_scroll = 0; fine_scroll = 0; v_addr = 0; addr_hi = 0;
      data_buffer = 0; scanline = 0;
      foreach (vram[i]) begin
         vram[i] = 8'd0;
         vram_written[i] = 1'b0;
      end
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      for (phase = 0; phase < 4; phase++) begin
         write_settings(mirror_plan[phase], lock_plan[phase]);
         if (phase == 0) begin
            // directed: field extremes, every register and the odd cases
            send_word(OP_READ, REG_STATUS, 8'hff);
            send_word(OP_WRITE, REG_STATUS, 8'hff);
            send_word(OP_NONE, 3'd7, 8'hff);
            send_word(OP_WRITE, REG_CTRL1, 8'hff);
            send_word(OP_WRITE, REG_CTRL2, 8'h00);
            send_word(OP_WRITE, REG_CTRL2, 8'hff);
            send_word(OP_WRITE, REG_OAMADR, 8'hff);
            send_word(OP_WRITE, REG_OAMDAT, 8'h00);
            send_word(OP_WRITE, REG_OAMDAT, 8'hff);
            send_word(OP_WRITE, REG_SCROLL, 8'hff);
            send_word(OP_WRITE, REG_SCROLL, 8'h00);
            set_vram_address(16'hff10);
            send_word(OP_WRITE, REG_DATA, 8'haa);
            set_vram_address(16'h3f00);
            send_word(OP_READ, REG_DATA, 8'h00);
            send_word(OP_READ, REG_DATA, 8'h00);
            send_word(OP_TICK, 3'd0, 8'h00);
            send_word(OP_TICK, 3'd7, 8'hff);
            send_word(OP_WRITE, REG_CTRL1, 8'h00);
         end
         while (words_sent < (phase + 1) * 290) begin
            kind = $urandom_range(0, 99);
            if (words_sent > 1030) quiet = 1'b1;
            if (kind < 30) begin
               // fill a run of video memory
               base = pick_base();
               set_vram_address(base);
               n = $urandom_range(1, 8);
               repeat (n) send_word(OP_WRITE, REG_DATA, 8'($urandom));
            end else if (kind < 50) begin
               // read back the last run through the buffer
               set_vram_address(base);
               n = $urandom_range(1, 9);
               repeat (n) send_word(OP_READ, REG_DATA, 8'($urandom));
            end else if (kind < 75) begin
               n = $urandom_range(1, 40);
               repeat (n) send_word(OP_TICK, 3'($urandom), 8'($urandom));
            end else if (kind < 88) begin
               send_word(OP_WRITE, REG_CTRL1, 8'($urandom) | ($urandom_range(0, 1) ? 8'h80 : 8'h00));
               send_word(OP_WRITE, REG_CTRL2, 8'($urandom));
               send_word(OP_WRITE, REG_OAMADR, 8'($urandom));
               repeat ($urandom_range(1, 4)) send_word(OP_WRITE, REG_OAMDAT, 8'($urandom));
               send_word(OP_WRITE, REG_SCROLL, 8'($urandom));
               send_word(OP_WRITE, REG_SCROLL, 8'($urandom));
            end else begin
               send_word(op_type'($urandom_range(0, 3)), 3'($urandom), 8'($urandom));
            end
         end
         // let everything drain before the next setting
         wait_idle();
      end

      $display("covered %0d words over four memory settings: %0d reads, %0d ticks, %0d nmi",
               words_sent, reads_seen, ticks_seen, nmis_seen);
      if (errors == 0) $display("picture_unit_register_port_test: clean");
      else $display("picture_unit_register_port_test: errors");
      $finish;
   end

   // tally accepted request kinds for the summary
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) begin
         if (req_opcode == OP_READ) reads_seen++;
         if (req_opcode == OP_TICK) ticks_seen++;
      end
   end

endmodule
